### src/spr_pkg.sv
// shared types, widths and helpers for the sparse pivot row selector
// used by spr_inv and sparse_pivot_row_selector_core; no dependencies
`default_nettype none

package spr_pkg;

  // slot table depth and address width
  localparam int LEFT_COLUMNS = 4096;
  localparam int ADDR_W       = $clog2(LEFT_COLUMNS);

  // payload field widths
  localparam int ROW_W = 20;
  localparam int CNT_W = 20;
  localparam int COL_W = 12;
  localparam int VAL_W = 16;

  // inverse unit internals: signed coefficient width and shift count width
  localparam int T_W  = VAL_W + 2;
  localparam int SH_W = $clog2(VAL_W);

  // stream widths, padded to whole bytes
  localparam int S_DATA_W = 72;
  localparam int M_DATA_W = 48;

  // position of the highest set bit, zero for a zero word
  function automatic logic [SH_W-1:0] msb_index(input logic [VAL_W-1:0] v);
    logic [SH_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < VAL_W; i++) begin
      if (v[i]) idx = SH_W'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

### src/spr_inv.sv
// iterative modular inverse: extended euclid with a shift-subtract step
// unit, one quotient bit per cycle; depends on spr_pkg
`default_nettype none

module spr_inv (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [spr_pkg::VAL_W-1:0] value,
  input  wire logic [spr_pkg::VAL_W-1:0] modulus,
  output logic                           busy,
  output logic [spr_pkg::VAL_W-1:0]      result
);
  import spr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_RED  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_EUC  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]             state;
  logic [VAL_W-1:0]       value_q;
  logic [VAL_W-1:0]       mod_q;
  logic [VAL_W-1:0]       r0;
  logic [VAL_W-1:0]       r1;
  logic signed [T_W-1:0]  t0;
  logic signed [T_W-1:0]  t1;
  logic [SH_W-1:0]        k;

  logic [2*VAL_W-1:0]     sub;
  logic                   ge;
  logic [VAL_W-1:0]       rnew;
  logic signed [T_W-1:0]  tnew;
  logic signed [T_W:0]    t_ext;
  logic signed [T_W:0]    p_ext;
  logic signed [T_W:0]    t_norm;

  // shared step: compare and subtract the divisor shifted by k
  always_comb begin
    sub  = {{VAL_W{1'b0}}, r1} << k;
    ge   = {{VAL_W{1'b0}}, r0} >= sub;
    rnew = ge ? (r0 - sub[VAL_W-1:0]) : r0;
    tnew = ge ? (t0 - (t1 <<< k)) : t0;
  end

  // bring the final coefficient into range
  always_comb begin
    t_ext = {t0[T_W-1], t0};
    p_ext = {{(T_W+1-VAL_W){1'b0}}, mod_q};
    if (t_ext < 0) begin
      t_norm = t_ext + p_ext;
    end else if (t_ext >= p_ext) begin
      t_norm = t_ext - p_ext;
    end else begin
      t_norm = t_ext;
    end
  end

  assign busy = (state != S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            value_q <= value;
            mod_q   <= modulus;
            state   <= S_INIT;
          end
        end
        S_INIT: begin
          if (value_q == VAL_W'(1)) begin
            result <= VAL_W'(1);
            state  <= S_IDLE;
          end else if (mod_q < VAL_W'(2)) begin
            result <= '0;
            state  <= S_IDLE;
          end else if (value_q >= mod_q) begin
            r0    <= value_q;
            r1    <= mod_q;
            k     <= msb_index(value_q) - msb_index(mod_q);
            state <= S_RED;
          end else begin
            r0    <= mod_q;
            r1    <= value_q;
            t0    <= '0;
            t1    <= T_W'(1);
            state <= S_CHK;
          end
        end
        // reduce the scalar modulo the field characteristic
        S_RED: begin
          if (k == '0) begin
            r0    <= mod_q;
            r1    <= rnew;
            t0    <= '0;
            t1    <= T_W'(1);
            state <= S_CHK;
          end else begin
            r0 <= rnew;
            k  <= k - SH_W'(1);
          end
        end
        S_CHK: begin
          if (r1 == '0) begin
            state <= S_FIN;
          end else begin
            k     <= msb_index(r0) - msb_index(r1);
            state <= S_EUC;
          end
        end
        // one euclid division, a quotient bit per cycle, swap at the end
        S_EUC: begin
          if (k == '0) begin
            r0    <= r1;
            r1    <= rnew;
            t0    <= t1;
            t1    <= tnew;
            state <= S_CHK;
          end else begin
            r0 <= rnew;
            t0 <= tnew;
            k  <= k - SH_W'(1);
          end
        end
        S_FIN: begin
          if (r0 != VAL_W'(1)) begin
            result <= '0;
          end else begin
            result <= t_norm[VAL_W-1:0];
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### src/sparse_pivot_row_selector_core.sv
// top level of the sparse pivot row selector: slot table, sequencer and
// output register; depends on spr_pkg and spr_inv
//
// usage:
//  - s_* channel takes one row descriptor per transfer; has_left is on s_tuser
//  - m_* channel gives zero, one or two results per row; m_tlast marks the
//    final result of a row and m_tuser is to_top
//  - cfg_we/cfg_wdata write prime_modulus; write only while the block is idle
//  - after reset the slot table is cleared, one entry a cycle: s_tready stays
//    low until all 4096 entries are cleared, config writes are taken as ever
//  - a row with zero count gives nothing; a row without a left entry goes to
//    the bottom at once, a row that loses its slot after the table read
//  - a top row waits for the inverse unit: a start step, a step per
//    quotient bit while reducing the scalar, per euclid step a check step
//    and a step per quotient bit, then a check and a finish step; the
//    displaced row goes out while the inverse runs; the table read is
//    registered
//  - s_tready is high whenever the sequencer is idle, even while a result
//    waits in the output register; a stalled receiver holds the sequencer
//    at its next emit step
`default_nettype none

module sparse_pivot_row_selector_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // row_id[19:0], entry_count[39:20], lead_column[51:40], lead_value[67:52]
  input  wire logic [spr_pkg::S_DATA_W-1:0] s_tdata,
  // has_left[0]
  input  wire logic                         s_tuser,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // out_row_id[19:0], pivot_slot[31:20], multiplier[47:32]
  output logic [spr_pkg::M_DATA_W-1:0]      m_tdata,
  // to_top[0]
  output logic                              m_tuser,
  output logic                              m_tlast,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  input  wire logic                         cfg_we,
  input  wire logic [spr_pkg::VAL_W-1:0]    cfg_wdata
);
  import spr_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_LOOK   = 3'd2;
  localparam logic [2:0] S_EMIT_B = 3'd3;
  localparam logic [2:0] S_EMIT_D = 3'd4;
  localparam logic [2:0] S_EMIT_T = 3'd5;

  localparam logic [VAL_W-1:0] MOD_RESET = VAL_W'(65521);

  logic [2:0]        state;
  logic [ADDR_W-1:0] clr_addr;
  logic [VAL_W-1:0]  prime_modulus;

  // latched item
  logic [ROW_W-1:0]  row_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [COL_W-1:0]  col_q;
  logic [VAL_W-1:0]  lead_q;
  logic [ROW_W-1:0]  disp_row;

  // slot table
  logic              taken_mem [LEFT_COLUMNS];
  logic [ROW_W-1:0]  row_mem   [LEFT_COLUMNS];
  logic [CNT_W-1:0]  cnt_mem   [LEFT_COLUMNS];
  logic              rd_taken;
  logic [ROW_W-1:0]  rd_row;
  logic [CNT_W-1:0]  rd_cnt;

  logic [ROW_W-1:0]  in_row;
  logic [CNT_W-1:0]  in_cnt;
  logic [COL_W-1:0]  in_col;
  logic [VAL_W-1:0]  in_lead;
  logic              in_xfer;
  logic              out_free;
  logic              out_load;
  logic              tbl_we;
  logic              inv_start;
  logic              inv_busy;
  logic [VAL_W-1:0]  inv_result;

  // input field split
  assign in_row  = s_tdata[ROW_W-1:0];
  assign in_cnt  = s_tdata[ROW_W+CNT_W-1:ROW_W];
  assign in_col  = s_tdata[ROW_W+CNT_W+COL_W-1:ROW_W+CNT_W];
  assign in_lead = s_tdata[ROW_W+CNT_W+COL_W+VAL_W-1:ROW_W+CNT_W+COL_W];

  assign s_tready = (state == S_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // output register loads on an emit step with room, the top-row step only once the inverse is done
  assign out_load = out_free && ((state == S_EMIT_B) || (state == S_EMIT_D) ||
                                 ((state == S_EMIT_T) && !inv_busy));

  // table update and inverse start when the new row wins its slot
  assign tbl_we    = (state == S_LOOK) && !(rd_taken && (rd_cnt < cnt_q));
  assign inv_start = tbl_we;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      prime_modulus <= MOD_RESET;
    end else if (cfg_we) begin
      prime_modulus <= cfg_wdata;
    end
  end

  // taken bits, cleared by a sweep after reset
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      taken_mem[clr_addr] <= 1'b0;
    end else if (tbl_we) begin
      taken_mem[col_q[ADDR_W-1:0]] <= 1'b1;
    end
    rd_taken <= taken_mem[in_col[ADDR_W-1:0]];
  end

  // row id and count of each slot's top row
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      row_mem[col_q[ADDR_W-1:0]] <= row_q;
      cnt_mem[col_q[ADDR_W-1:0]] <= cnt_q;
    end
    rd_row <= row_mem[in_col[ADDR_W-1:0]];
    rd_cnt <= cnt_mem[in_col[ADDR_W-1:0]];
  end

  // item latch
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      row_q  <= in_row;
      cnt_q  <= in_cnt;
      col_q  <= in_col;
      lead_q <= in_lead;
    end
    if (state == S_LOOK) begin
      disp_row <= rd_row;
    end
  end

  spr_inv u_inv (
    .clk     (clk),
    .rst     (rst),
    .start   (inv_start),
    .value   (lead_q),
    .modulus (prime_modulus),
    .busy    (inv_busy),
    .result  (inv_result)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // output valid: set on a load, cleared once the transfer is taken
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(LEFT_COLUMNS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer && (in_cnt != '0)) begin
            if (!s_tuser || (32'(in_col) >= 32'(LEFT_COLUMNS))) begin
              state <= S_EMIT_B;
            end else begin
              state <= S_LOOK;
            end
          end
        end
        // registered table read is ready here
        S_LOOK: begin
          if (rd_taken && (rd_cnt < cnt_q)) begin
            state <= S_EMIT_B;
          end else if (rd_taken) begin
            state <= S_EMIT_D;
          end else begin
            state <= S_EMIT_T;
          end
        end
        // new row goes to the bottom
        S_EMIT_B: begin
          if (out_load) begin
            m_tdata  <= {VAL_W'(1), COL_W'(0), row_q};
            m_tuser  <= 1'b0;
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        // displaced top row goes to the bottom
        S_EMIT_D: begin
          if (out_load) begin
            m_tdata  <= {VAL_W'(1), COL_W'(0), disp_row};
            m_tuser  <= 1'b0;
            m_tlast  <= 1'b0;
            state    <= S_EMIT_T;
          end
        end
        // new top row with its multiplier
        S_EMIT_T: begin
          if (out_load) begin
            m_tdata  <= {inv_result, col_q, row_q};
            m_tuser  <= 1'b1;
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### dv/sparse_pivot_row_selector_core_tb.sv
// testbench for sparse_pivot_row_selector_core: drives row descriptors,
// predicts the placements and checks every result transfer
// depends on spr_pkg and the block under test
`timescale 1ns / 100ps

module sparse_pivot_row_selector_core_tb;
  import spr_pkg::*;

  localparam int WATCHDOG_CYCLES  = 20000;
  localparam int DRAIN_CYCLES     = 120;
  localparam int ROWS_PER_PHASE   = 123;
  localparam int LONG_HOLD_AT     = 300;
  localparam int LONG_HOLD_CYCLES = 500;
  localparam logic [VAL_W-1:0] PHASE_MODULI [6] = '{
    16'd2, 16'd65535, 16'd257, 16'd65521, 16'd7, 16'd3
  };

  typedef struct packed {
    logic [ROW_W-1:0] row_id;
    logic [CNT_W-1:0] entry_count;
    logic             has_left;
    logic [COL_W-1:0] lead_column;
    logic [VAL_W-1:0] lead_value;
  } row_t;

  typedef struct packed {
    logic [ROW_W-1:0] out_row_id;
    logic             to_top;
    logic [COL_W-1:0] pivot_slot;
    logic [VAL_W-1:0] multiplier;
    logic             last;
  } placement_t;

  // pivot table predictor and queue of pending placements
  class pivot_scoreboard;
    logic [VAL_W-1:0] modulus;
    bit               slot_taken [LEFT_COLUMNS];
    logic [ROW_W-1:0] slot_row   [LEFT_COLUMNS];
    logic [CNT_W-1:0] slot_count [LEFT_COLUMNS];
    placement_t       placements_due [$];
    int unsigned      mismatches;

    function new();
      modulus = 16'd65521;
      foreach (slot_taken[i]) slot_taken[i] = 1'b0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return placements_due.size();
    endfunction

    // extended euclid over the field, zero when no inverse exists
    function logic [VAL_W-1:0] lead_inverse(logic [VAL_W-1:0] v);
      longint pm, r0, r1, t0, t1, q, tmp;
      if (v == 1) return 1;
      if (modulus < 2) return 0;
      pm = modulus;
      r0 = pm;
      r1 = v % modulus;
      t0 = 0;
      t1 = 1;
      while (r1 != 0) begin
        q   = r0 / r1;
        tmp = r0 - q * r1;
        r0  = r1;
        r1  = tmp;
        tmp = t0 - q * t1;
        t0  = t1;
        t1  = tmp;
      end
      if (r0 != 1) return 0;
      t0 = t0 % pm;
      if (t0 < 0) t0 += pm;
      return t0[VAL_W-1:0];
    endfunction

    function void push_placement(logic [ROW_W-1:0] id, logic top, logic [COL_W-1:0] slot,
                                 logic [VAL_W-1:0] mult, logic fin);
      placement_t p;
      p.out_row_id = id;
      p.to_top     = top;
      p.pivot_slot = slot;
      p.multiplier = mult;
      p.last       = fin;
      placements_due = {placements_due, p};
    endfunction

    // accepted row: update the slot table and queue what it causes
    function void note_row(row_t r);
      logic [COL_W-1:0] col;
      col = r.lead_column;
      if (r.entry_count == 0) return;
      if (!r.has_left || (slot_taken[col] && slot_count[col] < r.entry_count)) begin
        push_placement(r.row_id, 1'b0, '0, 16'd1, 1'b1);
        return;
      end
      // displaced top row drops to the bottom first
      if (slot_taken[col]) push_placement(slot_row[col], 1'b0, '0, 16'd1, 1'b0);
      slot_taken[col] = 1'b1;
      slot_row[col]   = r.row_id;
      slot_count[col] = r.entry_count;
      push_placement(r.row_id, 1'b1, col, lead_inverse(r.lead_value), 1'b1);
    endfunction

    // result transfer: compare with the oldest pending placement
    function void check_result(placement_t got);
      placement_t want;
      if (placements_due.size() == 0) begin
        $error("unexpected result transfer for row %0h", got.out_row_id);
        mismatches++;
        return;
      end
      want = placements_due.pop_front();
      if (got.out_row_id !== want.out_row_id) begin
        $error("out_row_id: expected %0h, got %0h", want.out_row_id, got.out_row_id);
        mismatches++;
      end
      if (got.to_top !== want.to_top) begin
        $error("to_top: expected %0d, got %0d", want.to_top, got.to_top);
        mismatches++;
      end
      if (got.pivot_slot !== want.pivot_slot) begin
        $error("pivot_slot: expected %0d, got %0d", want.pivot_slot, got.pivot_slot);
        mismatches++;
      end
      if (got.multiplier !== want.multiplier) begin
        $error("multiplier: expected %0d, got %0d", want.multiplier, got.multiplier);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic [S_DATA_W-1:0] s_tdata;
  logic                s_tuser;
  logic                s_tvalid;
  logic                s_tready;
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tuser;
  logic                m_tlast;
  logic                m_tvalid;
  logic                m_tready;
  logic                cfg_we;
  logic [VAL_W-1:0]    cfg_wdata;

  pivot_scoreboard sb;
  int unsigned     rows_taken = 0;
  int unsigned     burst_left = 0;

  sparse_pivot_row_selector_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // observe both channels at each edge
  always @(posedge clk) begin : transfer_monitor
    row_t       seen;
    placement_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        seen.row_id      = s_tdata[19:0];
        seen.entry_count = s_tdata[39:20];
        seen.lead_column = s_tdata[51:40];
        seen.lead_value  = s_tdata[67:52];
        seen.has_left    = s_tuser;
        sb.note_row(seen);
        rows_taken++;
      end
      if (m_tvalid && m_tready) begin
        got.out_row_id = m_tdata[19:0];
        got.pivot_slot = m_tdata[31:20];
        got.multiplier = m_tdata[47:32];
        got.to_top     = m_tuser;
        got.last       = m_tlast;
        sb.check_result(got);
      end
    end
  end

  // end the run when no transfer happens for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("sparse_pivot_row_selector_core_tb failed");
    $finish;
  end

  // receiver stalls in stretches of varying duty, plus one long hold-off
  initial begin : result_sink
    int unsigned stretch, duty;
    bit          held_once;
    held_once = 1'b0;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!held_once && rows_taken >= LONG_HOLD_AT) begin
        held_once = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      stretch = $urandom_range(10, 80);
      case ($urandom_range(3))
        0:       duty = 100;
        1:       duty = 70;
        2:       duty = 30;
        default: duty = 0;
      endcase
      repeat (stretch) begin
        m_tready <= ($urandom_range(99) < duty);
        @(posedge clk);
      end
    end
  end

  function automatic row_t make_row(logic [ROW_W-1:0] id, logic [CNT_W-1:0] cnt, logic left,
                                    logic [COL_W-1:0] col, logic [VAL_W-1:0] val);
    row_t r;
    r.row_id      = id;
    r.entry_count = cnt;
    r.has_left    = left;
    r.lead_column = col;
    r.lead_value  = val;
    return r;
  endfunction

  // mostly sparse rows on a few hot columns so slots collide often
  function automatic row_t random_row();
    row_t        r;
    int unsigned pick;
    r.row_id = ROW_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 8)       r.entry_count = '0;
    else if (pick < 70) r.entry_count = CNT_W'($urandom_range(1, 12));
    else if (pick < 90) r.entry_count = CNT_W'($urandom_range(1, 300));
    else                r.entry_count = CNT_W'($urandom);
    r.has_left = ($urandom_range(9) != 0);
    pick = $urandom_range(15);
    if ($urandom_range(9) < 7) r.lead_column = (pick == 15) ? COL_W'(4095) : COL_W'(pick);
    else                       r.lead_column = COL_W'($urandom);
    case ($urandom_range(9))
      0:       r.lead_value = 16'd1;
      1:       r.lead_value = 16'd0;
      2:       r.lead_value = sb.modulus;
      3:       r.lead_value = VAL_W'(sb.modulus + 1);
      4:       r.lead_value = 16'hffff;
      default: r.lead_value = VAL_W'($urandom);
    endcase
    return r;
  endfunction

  // offer one row, idling between bursts
  task automatic offer_row(row_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_tdata  <= {4'b0, r.lead_value, r.lead_column, r.entry_count, r.row_id};
    s_tuser  <= r.has_left;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  // wait for every placement, then let a zero row finish
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_modulus(logic [VAL_W-1:0] p);
    cfg_wdata <= p;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.modulus = p;
  endtask

  initial begin : stimulus
    sb = new();
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    write_modulus(16'd65521);

    // directed: drops, bottoms, ties, displacement and inverse corner cases
    offer_row(make_row(20'h0, 20'd0, 1'b1, 12'd5, 16'd3));
    offer_row(make_row(20'hfffff, 20'hfffff, 1'b0, 12'hfff, 16'hffff));
    offer_row(make_row(20'h1, 20'd10, 1'b1, 12'd0, 16'd1));
    offer_row(make_row(20'h2, 20'd10, 1'b1, 12'd0, 16'd2));
    offer_row(make_row(20'h3, 20'd11, 1'b1, 12'd0, 16'd9));
    offer_row(make_row(20'h4, 20'd3, 1'b1, 12'd0, 16'd65521));
    offer_row(make_row(20'h5, 20'hfffff, 1'b1, 12'hfff, 16'hffff));
    offer_row(make_row(20'h6, 20'd1, 1'b1, 12'hfff, 16'd0));
    offer_row(make_row(20'h7, 20'd1, 1'b0, 12'd0, 16'd4));
    offer_row(make_row(20'h8, 20'd0, 1'b0, 12'd0, 16'd4));
    offer_row(make_row(20'h9, 20'd1, 1'b1, 12'd7, 16'd65520));
    offer_row(make_row(20'ha, 20'd2, 1'b1, 12'd7, 16'd5));
    offer_row(make_row(20'hb, 20'd1, 1'b1, 12'd7, 16'd1));
    wait_idle();

    // random phases under several moduli, smallest and largest included
    foreach (PHASE_MODULI[i]) begin
      write_modulus(PHASE_MODULI[i]);
      repeat (ROWS_PER_PHASE) offer_row(random_row());
      wait_idle();
    end

    if (sb.pending() != 0) begin
      $error("%0d placements never arrived", sb.pending());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("sparse_pivot_row_selector_core_tb passed");
    end else begin
      $display("sparse_pivot_row_selector_core_tb failed");
    end
    $finish;
  end

endmodule

### files.f
src/spr_pkg.sv
src/spr_inv.sv
src/sparse_pivot_row_selector_core.sv
dv/sparse_pivot_row_selector_core_tb.sv
